FILE: rtl/ldlb_pkg.sv
package ldlb_pkg;

    localparam int ALT_W     = 18;
    localparam int RATE_W    = 15;
    localparam int MS_W      = 16;
    localparam int LAND_W    = 17;
    localparam int MINRATE_W = 14;
    localparam int DELAY_W   = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LAND_ALTITUDE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DESCENT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAND_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_DELAY   = 2'd3;

    localparam logic [LAND_W-1:0]    LAND_ALTITUDE_RST = 17'd500;
    localparam logic [MINRATE_W-1:0] MIN_DESCENT_RST   = 14'd20;
    localparam logic [MS_W-1:0]      LAND_TIMEOUT_RST  = 16'd3000;
    localparam logic [MS_W-1:0]      START_DELAY_RST   = 16'd1000;

    typedef enum logic [1:0] {
        PH_WAIT_ALT = 2'd0,
        PH_DELAY    = 2'd1,
        PH_DESCENT  = 2'd2,
        PH_STOPPED  = 2'd3
    } phase_t;

    typedef struct packed {
        logic [LAND_W-1:0]    land_altitude_cm;
        logic [MINRATE_W-1:0] min_descent_rate;
        logic [MS_W-1:0]      land_timeout_ms;
        logic [MS_W-1:0]      start_delay_ms;
    } cfg_t;

    typedef struct packed {
        phase_t              phase;
        logic [MS_W-1:0]     bucket;
        logic [DELAY_W-1:0]  delay_elapsed;
    } state_t;

    typedef struct packed {
        logic            landed;
        phase_t          phase;
        logic [MS_W-1:0] bucket_ms;
    } result_t;

endpackage

FILE: rtl/landing_detector_leaky_bucket_unit.sv
// an accepted word is registered in the result register, or in the skid stage while output stalls
// throughput: one word per cycle while in_stall is low, set by the combinational update of phase and bucket
// a skid stage behind the result register takes one more word while output stalls
// reset: rst_n clears phase, bucket, delay counter and the valid flags of both output
// stages at once and loads the register defaults (500 cm, 20 cm/s, 3000 ms, 1000 ms)
module landing_detector_leaky_bucket_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic        [ldlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [ldlb_pkg::CFG_W-1:0]      cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   restart,
    input  logic signed [ldlb_pkg::ALT_W-1:0]      altitude_cm,
    input  logic signed [ldlb_pkg::RATE_W-1:0]     climb_rate,
    input  logic        [ldlb_pkg::MS_W-1:0]       elapsed_ms,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic                                   landed,
    output logic        [1:0]                      phase,
    output logic        [ldlb_pkg::MS_W-1:0]       bucket_ms
);
    import ldlb_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t step_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    in_accept;
    logic    out_free;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid & ~skid_valid_reg;
    assign out_free  = ~out_valid_reg | ~out_stall;

    ldlb_step u_step (
        .cfg         (cfg_reg),
        .state       (state_reg),
        .restart     (restart),
        .altitude_cm (altitude_cm),
        .climb_rate  (climb_rate),
        .elapsed_ms  (elapsed_ms),
        .state_next  (state_next),
        .result      (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.land_altitude_cm <= LAND_ALTITUDE_RST;
            cfg_reg.min_descent_rate <= MIN_DESCENT_RST;
            cfg_reg.land_timeout_ms  <= LAND_TIMEOUT_RST;
            cfg_reg.start_delay_ms   <= START_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LAND_ALTITUDE: cfg_reg.land_altitude_cm <= cfg_data[LAND_W-1:0];
                REG_MIN_DESCENT:   cfg_reg.min_descent_rate <= cfg_data[MINRATE_W-1:0];
                REG_LAND_TIMEOUT:  cfg_reg.land_timeout_ms  <= cfg_data[MS_W-1:0];
                REG_START_DELAY:   cfg_reg.start_delay_ms   <= cfg_data[MS_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase         <= PH_WAIT_ALT;
            state_reg.bucket        <= '0;
            state_reg.delay_elapsed <= '0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (!out_stall)
                skid_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
            if (!out_free)
                skid_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
                out_reg <= skid_reg;
        end
        else if (in_accept)
        begin
            if (out_free)
                out_reg <= step_result;
            else
                skid_reg <= step_result;
        end
    end

    assign out_valid = out_valid_reg;
    assign landed    = out_reg.landed;
    assign phase     = out_reg.phase;
    assign bucket_ms = out_reg.bucket_ms;

endmodule

FILE: rtl/ldlb_step.sv
module ldlb_step (
    input  ldlb_pkg::cfg_t                       cfg,
    input  ldlb_pkg::state_t                     state,
    input  logic                                 restart,
    input  logic signed [ldlb_pkg::ALT_W-1:0]    altitude_cm,
    input  logic signed [ldlb_pkg::RATE_W-1:0]   climb_rate,
    input  logic        [ldlb_pkg::MS_W-1:0]     elapsed_ms,
    output ldlb_pkg::state_t                     state_next,
    output ldlb_pkg::result_t                    result
);
    import ldlb_pkg::*;

    always_comb
    begin
        logic [ALT_W-1:0]   alt_u;
        logic [ALT_W-1:0]   alt_abs;
        logic [RATE_W-1:0]  rate_u;
        logic [RATE_W-1:0]  rate_abs;
        logic [DELAY_W:0]   delay_sum;
        logic [DELAY_W-1:0] delay_new;
        logic [MS_W+1:0]    fill_sum;
        logic [MS_W-1:0]    drained;
        logic               landed;

        alt_u     = altitude_cm;
        alt_abs   = alt_u[ALT_W-1] ? (~alt_u + ALT_W'(1)) : alt_u;
        rate_u    = climb_rate;
        rate_abs  = rate_u[RATE_W-1] ? (~rate_u + RATE_W'(1)) : rate_u;
        delay_sum = {1'b0, state.delay_elapsed} + {2'b00, elapsed_ms};
        delay_new = delay_sum[DELAY_W] ? '1 : delay_sum[DELAY_W-1:0];
        fill_sum  = {2'b00, state.bucket} + {1'b0, elapsed_ms, 1'b0};
        drained   = (state.bucket > elapsed_ms) ? (state.bucket - elapsed_ms) : '0;
        landed    = 1'b0;

        state_next = state;
        if (restart)
        begin
            state_next.phase         = PH_WAIT_ALT;
            state_next.bucket        = '0;
            state_next.delay_elapsed = '0;
        end
        else
        begin
            unique case (state.phase)
                PH_WAIT_ALT:
                begin
                    if (alt_abs < {1'b0, cfg.land_altitude_cm})
                    begin
                        state_next.bucket        = cfg.start_delay_ms;
                        state_next.delay_elapsed = '0;
                        state_next.phase         = PH_DELAY;
                    end
                end
                PH_DELAY:
                begin
                    state_next.delay_elapsed = delay_new;
                    if (delay_new > {1'b0, cfg.start_delay_ms})
                    begin
                        state_next.bucket = cfg.land_timeout_ms;
                        state_next.phase  = PH_DESCENT;
                    end
                end
                PH_DESCENT:
                begin
                    if (rate_abs < {1'b0, cfg.min_descent_rate})
                    begin
                        state_next.bucket = drained;
                        if (drained == '0)
                            state_next.phase = PH_STOPPED;
                    end
                    else if (fill_sum < {2'b00, cfg.land_timeout_ms})
                        state_next.bucket = fill_sum[MS_W-1:0];
                    else
                        state_next.bucket = cfg.land_timeout_ms;
                end
                PH_STOPPED:
                begin
                    landed = 1'b1;
                end
            endcase
        end

        result.landed    = landed;
        result.phase     = state_next.phase;
        result.bucket_ms = state_next.bucket;
    end

endmodule

FILE: rtl/ldlb_checker.sv
module ldlb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic                             landed,
    input logic [1:0]                       phase,
    input logic [ldlb_pkg::MS_W-1:0]        bucket_ms
);
    import ldlb_pkg::*;

    // out_valid is always high in the cycle after a word is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted word not presented");

    // landed is only reported from the stopped phase
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && landed |-> phase == PH_STOPPED)
        else $error("landed outside stopped phase");

    // stopped is reached only by draining the bucket to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == PH_STOPPED |-> bucket_ms == '0)
        else $error("stopped with nonempty bucket");

    // waiting for altitude means reset or restart, bucket empty
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == PH_WAIT_ALT |-> bucket_ms == '0 && !landed)
        else $error("bucket set while waiting for altitude");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

endmodule

bind landing_detector_leaky_bucket_unit ldlb_checker u_ldlb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .landed    (landed),
    .phase     (phase),
    .bucket_ms (bucket_ms)
);

FILE: verif/landing_report_checker.sv
`timescale 1ns / 1ps

module landing_report_checker
    import ldlb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    restart,
    input  logic [ALT_W-1:0]        altitude_cm,
    input  logic [RATE_W-1:0]       climb_rate,
    input  logic [MS_W-1:0]         elapsed_ms,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic                    landed,
    input  logic [1:0]              phase,
    input  logic [MS_W-1:0]         bucket_ms,
    output int                      fail_count,
    output int                      pending,
    output int                      result_count,
    output int                      landed_count
);

    localparam logic [DELAY_W:0] DELAY_CAP = 131071;

    cfg_t               regs;
    phase_t             cur_phase;
    logic [MS_W-1:0]    cur_bucket;
    logic [DELAY_W-1:0] delay_ms;
    result_t            landing_reports[$];
    result_t            want;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        result_count = 0;
        landed_count = 0;
    end

    function automatic result_t advance_landing(input logic rs,
                                                input logic [ALT_W-1:0] alt,
                                                input logic [RATE_W-1:0] rate,
                                                input logic [MS_W-1:0] dt);
        logic [ALT_W-1:0]  alt_mag;
        logic [RATE_W-1:0] rate_mag;
        logic [ALT_W-1:0]  sum;
        result_t           r;
        alt_mag  = alt[ALT_W-1] ? ~alt + ALT_W'(1) : alt;
        rate_mag = rate[RATE_W-1] ? ~rate + RATE_W'(1) : rate;
        r.landed = 1'b0;
        if (rs)
        begin
            cur_phase  = PH_WAIT_ALT;
            cur_bucket = '0;
            delay_ms   = '0;
        end
        else
        begin
            case (cur_phase)
                PH_WAIT_ALT:
                begin
                    if (alt_mag < {1'b0, regs.land_altitude_cm})
                    begin
                        cur_bucket = regs.start_delay_ms;
                        delay_ms   = '0;
                        cur_phase  = PH_DELAY;
                    end
                end
                PH_DELAY:
                begin
                    sum      = {1'b0, delay_ms} + {2'b00, dt};
                    delay_ms = (sum > DELAY_CAP) ? DELAY_CAP[DELAY_W-1:0] : sum[DELAY_W-1:0];
                    if (delay_ms > {1'b0, regs.start_delay_ms})
                    begin
                        cur_bucket = regs.land_timeout_ms;
                        cur_phase  = PH_DESCENT;
                    end
                end
                PH_DESCENT:
                begin
                    if (rate_mag < {1'b0, regs.min_descent_rate})
                    begin
                        cur_bucket = (cur_bucket > dt) ? cur_bucket - dt : '0;
                        if (cur_bucket == '0)
                            cur_phase = PH_STOPPED;
                    end
                    else
                    begin
                        sum        = {2'b00, cur_bucket} + {1'b0, dt, 1'b0};
                        cur_bucket = (sum < {2'b00, regs.land_timeout_ms}) ?
                                     sum[MS_W-1:0] : regs.land_timeout_ms;
                    end
                end
                default:
                begin
                    r.landed = 1'b1;
                end
            endcase
        end
        r.phase     = cur_phase;
        r.bucket_ms = cur_bucket;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.land_altitude_cm = LAND_ALTITUDE_RST;
            regs.min_descent_rate = MIN_DESCENT_RST;
            regs.land_timeout_ms  = LAND_TIMEOUT_RST;
            regs.start_delay_ms   = START_DELAY_RST;
            cur_phase             = PH_WAIT_ALT;
            cur_bucket            = '0;
            delay_ms              = '0;
            landing_reports.delete();
            pending               = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (landing_reports.size() == 0)
                begin
                    $error("result word with nothing expected: landed %0d phase %0d bucket %0d",
                           landed, phase, bucket_ms);
                    fail_count++;
                end
                else
                begin
                    want = landing_reports.pop_front();
                    result_count++;
                    if (landed)
                        landed_count++;
                    if (want.landed !== landed)
                    begin
                        $error("landed: expected %0d, got %0d", want.landed, landed);
                        fail_count++;
                    end
                    if (want.phase !== phase)
                    begin
                        $error("phase: expected %0d, got %0d", want.phase, phase);
                        fail_count++;
                    end
                    if (want.bucket_ms !== bucket_ms)
                    begin
                        $error("bucket_ms: expected %0d, got %0d", want.bucket_ms, bucket_ms);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LAND_ALTITUDE: regs.land_altitude_cm = cfg_data[LAND_W-1:0];
                    REG_MIN_DESCENT:   regs.min_descent_rate = cfg_data[MINRATE_W-1:0];
                    REG_LAND_TIMEOUT:  regs.land_timeout_ms  = cfg_data[MS_W-1:0];
                    REG_START_DELAY:   regs.start_delay_ms   = cfg_data[MS_W-1:0];
                    default:           ;
                endcase
            end
            if (in_valid && !in_stall)
                landing_reports.push_back(advance_landing(restart, altitude_cm,
                                                          climb_rate, elapsed_ms));
            pending = landing_reports.size();
        end
    end

endmodule

FILE: verif/landing_detector_leaky_bucket_unit_test.sv
`timescale 1ns / 1ps

module landing_detector_leaky_bucket_unit_test;

    import ldlb_pkg::*;

    localparam int RANDOM_WORDS = 450;
    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 60;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = REG_LAND_ALTITUDE;
    logic [CFG_W-1:0]       cfg_data    = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_stall;
    logic                   restart     = 1'b0;
    logic signed [ALT_W-1:0]  altitude_cm = '0;
    logic signed [RATE_W-1:0] climb_rate  = '0;
    logic [MS_W-1:0]        elapsed_ms  = '0;
    logic                   out_valid;
    logic                   out_stall   = 1'b0;
    logic                   landed;
    logic [1:0]             phase;
    logic [MS_W-1:0]        bucket_ms;

    int fail_count;
    int pending;
    int result_count;
    int landed_count;

    int words_sent  = 0;
    int settings    = 0;
    int burst_left  = 1;
    int quiet_words = 0;
    logic hold_req  = 1'b0;

    logic [LAND_W-1:0]    cur_land_alt = LAND_ALTITUDE_RST;
    logic [MINRATE_W-1:0] cur_min_rate = MIN_DESCENT_RST;

    always #5 clk = ~clk;

    landing_detector_leaky_bucket_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .restart     (restart),
        .altitude_cm (altitude_cm),
        .climb_rate  (climb_rate),
        .elapsed_ms  (elapsed_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .landed      (landed),
        .phase       (phase),
        .bucket_ms   (bucket_ms)
    );

    landing_report_checker landing_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .altitude_cm  (altitude_cm),
        .climb_rate   (climb_rate),
        .elapsed_ms   (elapsed_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .landed       (landed),
        .phase        (phase),
        .bucket_ms    (bucket_ms),
        .fail_count   (fail_count),
        .pending      (pending),
        .result_count (result_count),
        .landed_count (landed_count)
    );

    task automatic send_word(input logic rs, input logic signed [ALT_W-1:0] alt,
                             input logic signed [RATE_W-1:0] rate, input logic [MS_W-1:0] dt);
        in_valid    <= 1'b1;
        restart     <= rs;
        altitude_cm <= alt;
        climb_rate  <= rate;
        elapsed_ms  <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (quiet_words > 0)
            quiet_words--;
        else
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 16);
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
            end
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_W-1:0] la, input logic [CFG_W-1:0] mr,
                              input logic [CFG_W-1:0] tmo, input logic [CFG_W-1:0] dly);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LAND_ALTITUDE;
        cfg_data  <= la;
        @(posedge clk);
        cfg_index <= REG_MIN_DESCENT;
        cfg_data  <= mr;
        @(posedge clk);
        cfg_index <= REG_LAND_TIMEOUT;
        cfg_data  <= tmo;
        @(posedge clk);
        cfg_index <= REG_START_DELAY;
        cfg_data  <= dly;
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_land_alt = la[LAND_W-1:0];
        cur_min_rate = mr[MINRATE_W-1:0];
        settings++;
    endtask

    function automatic logic [CFG_W-1:0] pick_reg(input int typ_max, input int rst_val,
                                                  input int wmax);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CFG_W'(wmax);
            2:       return 17'h1FFFF;
            3:       return CFG_W'(rst_val);
            default: return CFG_W'($urandom_range(1, typ_max));
        endcase
    endfunction

    function automatic logic signed [ALT_W-1:0] low_altitude();
        int m;
        if (cur_land_alt == '0 || $urandom_range(0, 9) == 0)
            return ALT_W'($urandom);
        m = $urandom_range(0, cur_land_alt - 1);
        return ALT_W'($urandom_range(0, 1) ? -m : m);
    endfunction

    function automatic logic signed [ALT_W-1:0] high_altitude();
        int m;
        if ($urandom_range(0, 3) == 0)
            return ALT_W'($urandom);
        m = $urandom_range(cur_land_alt, 131071);
        return ALT_W'($urandom_range(0, 1) ? -m : m);
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate(input logic slow);
        int m;
        if ($urandom_range(0, 9) == 0)
            return RATE_W'($urandom);
        if (slow && cur_min_rate != '0)
            m = $urandom_range(0, cur_min_rate - 1);
        else
            m = $urandom_range(cur_min_rate, 16383);
        return RATE_W'($urandom_range(0, 1) ? -m : m);
    endfunction

    function automatic logic [MS_W-1:0] pick_elapsed();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return MS_W'($urandom);
            default: return MS_W'($urandom_range(0, 400));
        endcase
    endfunction

    // one approach: an optional restart, some high updates, then low altitude through delay and descent
    task automatic fly_once();
        int n_hi;
        int n_low;
        logic rs;
        if ($urandom_range(0, 3) == 0)
            send_word(1'b1, ALT_W'($urandom), RATE_W'($urandom), MS_W'($urandom));
        n_hi = $urandom_range(0, 3);
        repeat (n_hi)
            send_word($urandom_range(0, 39) == 0, high_altitude(),
                      pick_rate($urandom_range(0, 1) == 1), pick_elapsed());
        n_low = $urandom_range(4, 30);
        repeat (n_low)
        begin
            rs = ($urandom_range(0, 39) == 0);
            send_word(rs, low_altitude(), pick_rate($urandom_range(0, 4) != 0), pick_elapsed());
        end
    endtask

    // receiver: stretches of free flow, random stalls and periodic stalls, plus one long hold
    initial
    begin : receiver
        int   mode;
        int   len;
        int   period;
        logic hold_done;
        hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            mode   = $urandom_range(0, 2);
            len    = $urandom_range(20, 80);
            period = $urandom_range(2, 5);
            for (int i = 0; i < len; i++)
            begin
                if (hold_req && !hold_done)
                begin
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES)
                        @(posedge clk);
                    hold_done = 1'b1;
                end
                else
                begin
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 2) == 0);
                        default: out_stall <= ((i % period) == 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        int target;
        int phase_end;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default registers: altitude extremes, delay boundary, cap, drain to stop, landed
        send_word(1'b0, 131071, 0, 100);
        send_word(1'b0, -131072, 0, 100);
        send_word(1'b0, 100000, 16383, 16'hFFFF);
        send_word(1'b0, 500, -20, 0);
        send_word(1'b0, -499, -10000, 0);
        send_word(1'b0, -100000, 0, 1000);
        send_word(1'b0, 0, 0, 1);
        send_word(1'b0, 0, 16383, 16'hFFFF);
        send_word(1'b0, 0, -19, 1000);
        send_word(1'b0, 0, -16384, 100);
        send_word(1'b0, 0, 19, 0);
        send_word(1'b0, 0, 0, 16'hFFFF);
        send_word(1'b0, 0, 0, 0);
        send_word(1'b0, 131071, 16383, 16'hFFFF);
        send_word(1'b1, -100000, 0, 16'hFFFF);
        send_word(1'b0, -500, 0, 0);

        // zero timeout and zero delay, widest altitude and rate thresholds
        wait_idle();
        set_config(17'h1FFFF, 17'h1FFFF, '0, '0);
        send_word(1'b0, -131071, 0, 0);
        send_word(1'b0, 131070, 0, 0);
        send_word(1'b0, 0, 0, 0);
        send_word(1'b0, 0, 0, 1);
        send_word(1'b0, 0, 16383, 16'hFFFF);
        send_word(1'b0, 0, -16383, 7);
        send_word(1'b0, 0, 16382, 5);
        send_word(1'b0, 0, 0, 0);

        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            wait_idle();
            set_config(pick_reg(20000, LAND_ALTITUDE_RST, 131071),
                       pick_reg(2000, MIN_DESCENT_RST, 16383),
                       pick_reg(800, LAND_TIMEOUT_RST, 65535),
                       pick_reg(600, START_DELAY_RST, 65535));
            if (!hold_req)
            begin
                quiet_words = 150;
                hold_req    = 1'b1;
            end
            phase_end = words_sent + $urandom_range(60, 90);
            while (words_sent < phase_end)
                fly_once();
        end

        wait_idle();
        repeat (5)
            @(posedge clk);
        $display("covered %0d updates across %0d register settings with stalls on both sides",
                 words_sent, settings + 1);
        $display("%0d results compared, %0d of them reporting landed", result_count, landed_count);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: landing_detector_leaky_bucket_unit.f
rtl/ldlb_pkg.sv
rtl/ldlb_step.sv
rtl/landing_detector_leaky_bucket_unit.sv
rtl/ldlb_checker.sv
verif/landing_report_checker.sv
verif/landing_detector_leaky_bucket_unit_test.sv
